// ===== rtl/qte_pkg.sv =====
// ----------------------------------------------------------------------------
// qte_pkg
// Shared types, constants and helper functions for the quaternion to
// Euler angle converter.
// ----------------------------------------------------------------------------
package qte_pkg;

    // Input field width, Q2.14.
    localparam int QW     = 16;
    // Width of the atan2 and square root arguments, Q28.
    localparam int ARG_W  = 34;
    // Clamped square root argument, always non-negative.
    localparam int SARG_W = 33;
    // Square root result width, Q28.
    localparam int ROOT_W = 31;
    // Working width of the digit-by-digit square root.
    localparam int SQ_W   = 63;
    // Number of square root steps, one result bit each.
    localparam int SQ_STEPS = 32;
    // CORDIC datapath width and Q30 angle width.
    localparam int CW     = 37;
    localparam int ZW     = 34;
    // Angle width before output conversion.
    localparam int ANG_W  = ZW + 2;
    // Width of the rounded Q13 angle before saturation.
    localparam int RND_W  = ANG_W - 17;
    // Output widths.
    localparam int FULL_W = 16;
    localparam int HALF_W = 15;
    // Number of entries in the arctangent table.
    localparam int MAX_STAGES = 24;

    localparam logic signed [ARG_W-1:0] ONE_Q28     = ARG_W'(268435456);
    localparam logic signed [ZW-1:0]    HALF_PI_Q30 = ZW'(1686629713);
    localparam logic signed [RND_W-1:0] LIM_FULL    = RND_W'(25736);
    localparam logic signed [RND_W-1:0] LIM_HALF    = RND_W'(12868);
    localparam logic signed [ANG_W-1:0] ROUND_HALF  = ANG_W'(65536);

    // Arguments for the roll and yaw arctangents.
    typedef struct packed {
        logic signed [ARG_W-1:0] sr;
        logic signed [ARG_W-1:0] cr;
        logic signed [ARG_W-1:0] sy;
        logic signed [ARG_W-1:0] cy;
    } rpy_args_t;

    // Arctangent of 2^-i in Q30 radians.
    function automatic logic signed [ZW-1:0] atan_q30(input int i);
        logic signed [ZW-1:0] r;
        case (i)
            0:  r = ZW'(843314856);
            1:  r = ZW'(497837829);
            2:  r = ZW'(263043836);
            3:  r = ZW'(133525158);
            4:  r = ZW'(67021686);
            5:  r = ZW'(33543515);
            6:  r = ZW'(16775850);
            7:  r = ZW'(8388437);
            8:  r = ZW'(4194282);
            9:  r = ZW'(2097149);
            10: r = ZW'(1048575);
            11: r = ZW'(524287);
            12: r = ZW'(262143);
            13: r = ZW'(131071);
            14: r = ZW'(65535);
            15: r = ZW'(32767);
            16: r = ZW'(16383);
            17: r = ZW'(8191);
            18: r = ZW'(4095);
            19: r = ZW'(2047);
            20: r = ZW'(1023);
            21: r = ZW'(511);
            22: r = ZW'(255);
            23: r = ZW'(127);
            default: r = '0;
        endcase
        return r;
    endfunction

    // Q30 angle to Q13 with round half up, then saturation to +/- lim.
    function automatic logic signed [RND_W-1:0] to_q13_sat(
        input logic signed [ANG_W-1:0] a,
        input logic signed [RND_W-1:0] lim
    );
        logic signed [ANG_W-1:0] s;
        logic signed [RND_W-1:0] r;
        s = (a + ROUND_HALF) >>> 17;
        r = s[RND_W-1:0];
        if (r > lim) begin
            r = lim;
        end else if (r < -lim) begin
            r = -lim;
        end
        return r;
    endfunction

endpackage

// ===== rtl/quaternion_to_euler_angles_unit.sv =====
// ----------------------------------------------------------------------------
// quaternion_to_euler_angles_unit
// Pipeline: two front-end stages (products, then sums), 32 square root stages,
// one pre-rotation stage, one stage per CORDIC iteration, rounding, output.
// Throughput: one word per cycle; when the consumer stalls, the two-entry
// output buffer takes one more word, then the input stalls until it drains.
// Reset: synchronous, active low; clears all valid bits, no clearing pass.
// ----------------------------------------------------------------------------
module quaternion_to_euler_angles_unit #(
    parameter int CORDIC_STAGES = 16
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic signed [qte_pkg::QW-1:0]        s_quat_w,
    input  logic signed [qte_pkg::QW-1:0]        s_quat_x,
    input  logic signed [qte_pkg::QW-1:0]        s_quat_y,
    input  logic signed [qte_pkg::QW-1:0]        s_quat_z,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic signed [qte_pkg::FULL_W-1:0]    m_roll_angle,
    output logic signed [qte_pkg::HALF_W-1:0]    m_pitch_angle,
    output logic signed [qte_pkg::FULL_W-1:0]    m_yaw_angle
);
    import qte_pkg::*;

    localparam int SIDE_W = $bits(rpy_args_t);

    logic              en;
    logic              fr_valid;
    rpy_args_t         fr_args, sq_args;
    logic [SARG_W-1:0] fr_a, fr_b;
    logic              sq_valid;
    logic [ROOT_W-1:0] sq_sa, sq_sb;
    logic [SIDE_W-1:0] sq_side;

    logic                 roll_valid, pitch_valid, yaw_valid;
    logic signed [ZW-1:0] roll_z, pitch_z, yaw_z;

    logic                     tail_vld_reg;
    logic signed [FULL_W-1:0] tail_roll_reg, tail_yaw_reg;
    logic signed [HALF_W-1:0] tail_pitch_reg;
    logic signed [RND_W-1:0]  roll_next, pitch_next, yaw_next;
    logic signed [ANG_W-1:0]  pitch_ang;

    logic                     out_vld_reg, skid_vld_reg;
    logic signed [FULL_W-1:0] out_roll_reg, out_yaw_reg, skid_roll_reg, skid_yaw_reg;
    logic signed [HALF_W-1:0] out_pitch_reg, skid_pitch_reg;

    // The whole pipeline moves while the spare output entry is free.
    assign en      = !skid_vld_reg;
    assign s_ready = en;

    qte_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s_valid),
        .quat_w    (s_quat_w),
        .quat_x    (s_quat_x),
        .quat_y    (s_quat_y),
        .quat_z    (s_quat_z),
        .out_valid (fr_valid),
        .out_args  (fr_args),
        .out_a     (fr_a),
        .out_b     (fr_b)
    );

    qte_sqrt #(
        .SIDE_W (SIDE_W)
    ) u_sqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (fr_valid),
        .in_a      (fr_a),
        .in_b      (fr_b),
        .in_side   (fr_args),
        .out_valid (sq_valid),
        .out_sa    (sq_sa),
        .out_sb    (sq_sb),
        .out_side  (sq_side)
    );

    assign sq_args = rpy_args_t'(sq_side);

    qte_cordic #(
        .STAGES (CORDIC_STAGES)
    ) u_roll (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (sq_valid),
        .in_y      (sq_args.sr),
        .in_x      (sq_args.cr),
        .out_valid (roll_valid),
        .out_angle (roll_z)
    );

    qte_cordic #(
        .STAGES (CORDIC_STAGES)
    ) u_pitch (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (sq_valid),
        .in_y      (ARG_W'(sq_sa)),
        .in_x      (ARG_W'(sq_sb)),
        .out_valid (pitch_valid),
        .out_angle (pitch_z)
    );

    qte_cordic #(
        .STAGES (CORDIC_STAGES)
    ) u_yaw (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (sq_valid),
        .in_y      (sq_args.sy),
        .in_x      (sq_args.cy),
        .out_valid (yaw_valid),
        .out_angle (yaw_z)
    );

    // Rounding and saturation to Q13.
    always_comb begin
        pitch_ang  = (ANG_W'(pitch_z) <<< 1) - ANG_W'(HALF_PI_Q30);
        roll_next  = to_q13_sat(ANG_W'(roll_z), LIM_FULL);
        pitch_next = to_q13_sat(pitch_ang, LIM_HALF);
        yaw_next   = to_q13_sat(ANG_W'(yaw_z), LIM_FULL);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tail_vld_reg <= 1'b0;
        end else if (en) begin
            tail_vld_reg <= roll_valid && pitch_valid && yaw_valid;
        end
        if (en) begin
            tail_roll_reg  <= roll_next[FULL_W-1:0];
            tail_pitch_reg <= pitch_next[HALF_W-1:0];
            tail_yaw_reg   <= yaw_next[FULL_W-1:0];
        end
    end

    // Output register with a spare entry for a word that arrives while the
    // consumer stalls.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg  <= 1'b0;
            skid_vld_reg <= 1'b0;
        end else if (skid_vld_reg) begin
            if (m_ready) begin
                out_vld_reg  <= 1'b1;
                skid_vld_reg <= 1'b0;
            end
        end else if (tail_vld_reg) begin
            if (!out_vld_reg || m_ready) begin
                out_vld_reg <= 1'b1;
            end else begin
                skid_vld_reg <= 1'b1;
            end
        end else if (m_ready) begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (skid_vld_reg) begin
            if (m_ready) begin
                out_roll_reg  <= skid_roll_reg;
                out_pitch_reg <= skid_pitch_reg;
                out_yaw_reg   <= skid_yaw_reg;
            end
        end else if (tail_vld_reg) begin
            if (!out_vld_reg || m_ready) begin
                out_roll_reg  <= tail_roll_reg;
                out_pitch_reg <= tail_pitch_reg;
                out_yaw_reg   <= tail_yaw_reg;
            end else begin
                skid_roll_reg  <= tail_roll_reg;
                skid_pitch_reg <= tail_pitch_reg;
                skid_yaw_reg   <= tail_yaw_reg;
            end
        end
    end

    assign m_valid       = out_vld_reg;
    assign m_roll_angle  = out_roll_reg;
    assign m_pitch_angle = out_pitch_reg;
    assign m_yaw_angle   = out_yaw_reg;

endmodule

// ===== rtl/qte_front.sv =====
// ----------------------------------------------------------------------------
// qte_front
// Two-stage front end: the quaternion products, then the atan2 arguments
// and the clamped square root arguments for pitch.
// ----------------------------------------------------------------------------
module qte_front (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  en,
    input  logic                                  in_valid,
    input  logic signed [qte_pkg::QW-1:0]         quat_w,
    input  logic signed [qte_pkg::QW-1:0]         quat_x,
    input  logic signed [qte_pkg::QW-1:0]         quat_y,
    input  logic signed [qte_pkg::QW-1:0]         quat_z,
    output logic                                  out_valid,
    output qte_pkg::rpy_args_t                    out_args,
    output logic [qte_pkg::SARG_W-1:0]            out_a,
    output logic [qte_pkg::SARG_W-1:0]            out_b
);
    import qte_pkg::*;

    localparam int PW = 2 * QW;

    logic                 vld1_reg;
    logic signed [PW-1:0] wx_reg, yz_reg, xx_reg, yy_reg, zz_reg;
    logic signed [PW-1:0] wz_reg, xy_reg, wy_reg, xz_reg;

    logic                    vld2_reg;
    rpy_args_t               args_reg, args_next;
    logic [SARG_W-1:0]       a_reg, a_next, b_reg, b_next;
    logic signed [ARG_W-1:0] t_val, a_val, b_val;

    // Stage one: the nine products.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld1_reg <= 1'b0;
        end else if (en) begin
            vld1_reg <= in_valid;
        end
        if (en) begin
            wx_reg <= quat_w * quat_x;
            yz_reg <= quat_y * quat_z;
            xx_reg <= quat_x * quat_x;
            yy_reg <= quat_y * quat_y;
            zz_reg <= quat_z * quat_z;
            wz_reg <= quat_w * quat_z;
            xy_reg <= quat_x * quat_y;
            wy_reg <= quat_w * quat_y;
            xz_reg <= quat_x * quat_z;
        end
    end

    // Stage two: sums, the pitch term and the clamped root arguments.
    always_comb begin
        args_next.sr = (ARG_W'(wx_reg) + ARG_W'(yz_reg)) <<< 1;
        args_next.cr = ONE_Q28 - ((ARG_W'(xx_reg) + ARG_W'(yy_reg)) <<< 1);
        args_next.sy = (ARG_W'(wz_reg) + ARG_W'(xy_reg)) <<< 1;
        args_next.cy = ONE_Q28 - ((ARG_W'(yy_reg) + ARG_W'(zz_reg)) <<< 1);
        t_val = (ARG_W'(wy_reg) - ARG_W'(xz_reg)) <<< 1;
        a_val = ONE_Q28 + t_val;
        b_val = ONE_Q28 - t_val;
        a_next = a_val[ARG_W-1] ? '0 : a_val[SARG_W-1:0];
        b_next = b_val[ARG_W-1] ? '0 : b_val[SARG_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld2_reg <= 1'b0;
        end else if (en) begin
            vld2_reg <= vld1_reg;
        end
        if (en) begin
            args_reg <= args_next;
            a_reg    <= a_next;
            b_reg    <= b_next;
        end
    end

    assign out_valid = vld2_reg;
    assign out_args  = args_reg;
    assign out_a     = a_reg;
    assign out_b     = b_reg;

endmodule

// ===== rtl/qte_sqrt.sv =====
// ----------------------------------------------------------------------------
// qte_sqrt
// Pipelined floor square roots of (a << 28) and (b << 28), one result bit
// per stage, with a sideband word carried alongside.
// ----------------------------------------------------------------------------
module qte_sqrt #(
    parameter int SIDE_W = 136
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               en,
    input  logic                               in_valid,
    input  logic [qte_pkg::SARG_W-1:0]         in_a,
    input  logic [qte_pkg::SARG_W-1:0]         in_b,
    input  logic [SIDE_W-1:0]                  in_side,
    output logic                               out_valid,
    output logic [qte_pkg::ROOT_W-1:0]         out_sa,
    output logic [qte_pkg::ROOT_W-1:0]         out_sb,
    output logic [SIDE_W-1:0]                  out_side
);
    import qte_pkg::*;

    typedef struct packed {
        logic [SQ_W-1:0] v;
        logic [SQ_W-1:0] res;
    } sq_state_t;

    // One step of the bit-by-bit square root.
    function automatic sq_state_t sq_step(input sq_state_t s, input int k);
        logic [SQ_W-1:0] bitv;
        logic [SQ_W:0]   sum;
        sq_state_t       r;
        bitv = SQ_W'(1) << (SQ_W - 1 - 2 * k);
        sum  = {1'b0, s.res} + {1'b0, bitv};
        if ({1'b0, s.v} >= sum) begin
            r.v   = s.v - sum[SQ_W-1:0];
            r.res = (s.res >> 1) + bitv;
        end else begin
            r.v   = s.v;
            r.res = s.res >> 1;
        end
        return r;
    endfunction

    sq_state_t         sa_reg   [SQ_STEPS];
    sq_state_t         sb_reg   [SQ_STEPS];
    logic [SIDE_W-1:0] side_reg [SQ_STEPS];
    logic              vld_reg  [SQ_STEPS];
    sq_state_t         sa_in, sb_in;

    assign sa_in.v   = SQ_W'({in_a, 28'd0});
    assign sa_in.res = '0;
    assign sb_in.v   = SQ_W'({in_b, 28'd0});
    assign sb_in.res = '0;

    for (genvar k = 0; k < SQ_STEPS; k++) begin : g_step
        sq_state_t         sa_next, sb_next;
        logic [SIDE_W-1:0] side_next;
        logic              vld_next;

        // Select the previous stage, or the input for the first one.
        if (k == 0) begin : g_first
            always_comb begin
                sa_next   = sq_step(sa_in, k);
                sb_next   = sq_step(sb_in, k);
                side_next = in_side;
                vld_next  = in_valid;
            end
        end else begin : g_rest
            always_comb begin
                sa_next   = sq_step(sa_reg[k-1], k);
                sb_next   = sq_step(sb_reg[k-1], k);
                side_next = side_reg[k-1];
                vld_next  = vld_reg[k-1];
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[k] <= 1'b0;
            end else if (en) begin
                vld_reg[k] <= vld_next;
            end
            if (en) begin
                sa_reg[k]   <= sa_next;
                sb_reg[k]   <= sb_next;
                side_reg[k] <= side_next;
            end
        end
    end

    assign out_valid = vld_reg[SQ_STEPS-1];
    assign out_sa    = sa_reg[SQ_STEPS-1].res[ROOT_W-1:0];
    assign out_sb    = sb_reg[SQ_STEPS-1].res[ROOT_W-1:0];
    assign out_side  = side_reg[SQ_STEPS-1];

endmodule

// ===== rtl/qte_cordic.sv =====
// ----------------------------------------------------------------------------
// qte_cordic
// Pipelined vectoring CORDIC atan2: a quarter-turn pre-rotation stage,
// then one micro-rotation per stage. Angle out in Q30 radians.
// ----------------------------------------------------------------------------
module qte_cordic #(
    parameter int STAGES = 16
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               en,
    input  logic                               in_valid,
    input  logic signed [qte_pkg::ARG_W-1:0]   in_y,
    input  logic signed [qte_pkg::ARG_W-1:0]   in_x,
    output logic                               out_valid,
    output logic signed [qte_pkg::ZW-1:0]      out_angle
);
    import qte_pkg::*;

    logic signed [CW-1:0] x_reg [STAGES+1];
    logic signed [CW-1:0] y_reg [STAGES+1];
    logic signed [ZW-1:0] z_reg [STAGES+1];
    logic                 zero_reg [STAGES+1];
    logic                 vld_reg  [STAGES+1];

    logic signed [CW-1:0] xe, ye, x0_next, y0_next;
    logic signed [ZW-1:0] z0_next;

    // Pre-rotation into the right half plane.
    always_comb begin
        xe = CW'(in_x);
        ye = CW'(in_y);
        if (xe < 0) begin
            if (ye >= 0) begin
                x0_next = ye;
                y0_next = -xe;
                z0_next = HALF_PI_Q30;
            end else begin
                x0_next = -ye;
                y0_next = xe;
                z0_next = -HALF_PI_Q30;
            end
        end else begin
            x0_next = xe;
            y0_next = ye;
            z0_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg[0] <= 1'b0;
        end else if (en) begin
            vld_reg[0] <= in_valid;
        end
        if (en) begin
            x_reg[0]    <= x0_next;
            y_reg[0]    <= y0_next;
            z_reg[0]    <= z0_next;
            zero_reg[0] <= (in_x == '0) && (in_y == '0);
        end
    end

    // Micro-rotations; stage i shifts by i.
    for (genvar i = 0; i < STAGES; i++) begin : g_rot
        logic signed [CW-1:0] x_next, y_next;
        logic signed [ZW-1:0] z_next;

        always_comb begin
            if (y_reg[i] >= 0) begin
                x_next = x_reg[i] + (y_reg[i] >>> i);
                y_next = y_reg[i] - (x_reg[i] >>> i);
                z_next = z_reg[i] + atan_q30(i);
            end else begin
                x_next = x_reg[i] - (y_reg[i] >>> i);
                y_next = y_reg[i] + (x_reg[i] >>> i);
                z_next = z_reg[i] - atan_q30(i);
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[i+1] <= 1'b0;
            end else if (en) begin
                vld_reg[i+1] <= vld_reg[i];
            end
            if (en) begin
                x_reg[i+1]    <= x_next;
                y_reg[i+1]    <= y_next;
                z_reg[i+1]    <= z_next;
                zero_reg[i+1] <= zero_reg[i];
            end
        end
    end

    // A zero vector has angle zero.
    assign out_valid = vld_reg[STAGES];
    assign out_angle = zero_reg[STAGES] ? '0 : z_reg[STAGES];

endmodule

// ===== rtl/qte_checker.sv =====
// ----------------------------------------------------------------------------
// qte_checker
// Port-level checks for the converter: output ranges, reset and the
// behavior of the input ready against output stalls.
// ----------------------------------------------------------------------------
module qte_checker (
    input logic                                 aclk,
    input logic                                 aresetn,
    input logic                                 s_ready,
    input logic                                 m_valid,
    input logic                                 m_ready,
    input logic signed [qte_pkg::FULL_W-1:0]    m_roll_angle,
    input logic signed [qte_pkg::HALF_W-1:0]    m_pitch_angle,
    input logic signed [qte_pkg::FULL_W-1:0]    m_yaw_angle
);
    import qte_pkg::*;

    // A stalled output word stays presented.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("output word dropped while stalled");

    // Reset empties the output.
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("output valid after reset");

    // Input ready drops only when a stalled word is held.
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        $fell(s_ready) |-> $past(m_valid && !m_ready))
        else $error("input ready dropped without an output stall");

    // Angles stay within their saturation limits.
    a_pitch: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_pitch_angle <= 15'sd12868) && (m_pitch_angle >= -15'sd12868))
        else $error("pitch out of range");

    a_full: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_roll_angle <= 16'sd25736) && (m_roll_angle >= -16'sd25736)
                 && (m_yaw_angle <= 16'sd25736) && (m_yaw_angle >= -16'sd25736))
        else $error("roll or yaw out of range");

endmodule

bind quaternion_to_euler_angles_unit qte_checker u_qte_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_ready       (s_ready),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_roll_angle  (m_roll_angle),
    .m_pitch_angle (m_pitch_angle),
    .m_yaw_angle   (m_yaw_angle)
);

// ===== test/quaternion_to_euler_angles_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quaternion_to_euler_angles_unit_tb
// Drives quaternion words with random gaps and back-pressure, predicts the
// roll, pitch and yaw of each accepted word with a local fixed-point model,
// and checks every result word in order.
// ----------------------------------------------------------------------------
module quaternion_to_euler_angles_unit_tb;
    import qte_pkg::*;

    localparam int STAGES  = 16;
    localparam int LATENCY = STAGES + 37;
    localparam int WD_LIMIT = 20000;
    localparam int N_RANDOM = 1330;
    localparam int HOLD_CYCLES = 400;

    typedef struct {
        logic signed [15:0] w, x, y, z;
    } quat_t;

    typedef struct {
        logic signed [15:0] roll;
        logic signed [14:0] pitch;
        logic signed [15:0] yaw;
    } euler_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic signed [15:0] s_quat_w = '0, s_quat_x = '0, s_quat_y = '0, s_quat_z = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic signed [15:0] m_roll_angle;
    logic signed [14:0] m_pitch_angle;
    logic signed [15:0] m_yaw_angle;

    quat_t  pending_quats[$];
    euler_t expected_angles[$];
    int errors = 0;
    int words_in = 0;
    int words_out = 0;
    int idle_cycles = 0;
    int send_wait = 0;
    int recv_wait = 0;
    int hold_left = 0;
    bit in_fire = 0;
    bit out_fire = 0;
    bit hold_req = 0;
    bit hold_taken = 0;

    quaternion_to_euler_angles_unit #(.CORDIC_STAGES(STAGES)) dut (.*);

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Arctangent of 2^-i in Q30 radians.
    function automatic longint atan_step(int i);
        longint tbl[24] = '{843314856, 497837829, 263043836, 133525158, 67021686,
            33543515, 16775850, 8388437, 4194282, 2097149, 1048575, 524287,
            262143, 131071, 65535, 32767, 16383, 8191, 4095, 2047, 1023, 511,
            255, 127};
        return tbl[i];
    endfunction

    // Floor square root, one result bit per step.
    function automatic longint floor_sqrt(longint unsigned v);
        longint unsigned res, bitv;
        res = 0;
        bitv = 64'd1 << 62;
        for (int k = 0; k < 32; k++) begin
            if (v >= res + bitv) begin
                v = v - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return longint'(res);
    endfunction

    // Vectoring CORDIC arctangent with a quarter-turn pre-rotation, Q30.
    function automatic longint vector_angle(longint yv, longint xv);
        longint ang, nx, ny;
        ang = 0;
        if (xv == 0 && yv == 0) return 0;
        if (xv < 0) begin
            if (yv >= 0) begin
                nx = yv; ny = -xv; ang = 1686629713;
            end else begin
                nx = -yv; ny = xv; ang = -1686629713;
            end
            xv = nx; yv = ny;
        end
        for (int i = 0; i < STAGES && i < 24; i++) begin
            if (yv >= 0) begin
                nx = xv + (yv >>> i);
                ny = yv - (xv >>> i);
                ang += atan_step(i);
            end else begin
                nx = xv - (yv >>> i);
                ny = yv + (xv >>> i);
                ang -= atan_step(i);
            end
            xv = nx; yv = ny;
        end
        return ang;
    endfunction

    function automatic longint round_clamp(longint a, longint lim);
        longint r;
        r = (a + 65536) >>> 17;
        if (r > lim) r = lim;
        if (r < -lim) r = -lim;
        return r;
    endfunction

    function automatic euler_t euler_of(quat_t q);
        longint w, x, y, z, sr, cr, sy, cy, t, a, b;
        euler_t e;
        w = q.w; x = q.x; y = q.y; z = q.z;
        sr = 2 * (w * x + y * z);
        cr = 268435456 - 2 * (x * x + y * y);
        sy = 2 * (w * z + x * y);
        cy = 268435456 - 2 * (y * y + z * z);
        t = 2 * (w * y - x * z);
        a = 268435456 + t;
        b = 268435456 - t;
        if (a < 0) a = 0;
        if (b < 0) b = 0;
        e.roll  = 16'(round_clamp(vector_angle(sr, cr), 25736));
        e.pitch = 15'(round_clamp(2 * vector_angle(floor_sqrt(a << 28),
                  floor_sqrt(b << 28)) - 1686629713, 12868));
        e.yaw   = 16'(round_clamp(vector_angle(sy, cy), 25736));
        return e;
    endfunction

    function automatic quat_t make_quat(int w, int x, int y, int z);
        quat_t q;
        q.w = 16'(w); q.x = 16'(x); q.y = 16'(y); q.z = 16'(z);
        return q;
    endfunction

    // A roughly normalized rotation with random content.
    function automatic quat_t unit_quat();
        real c[4], n;
        quat_t q;
        n = 0.0;
        for (int i = 0; i < 4; i++) begin
            c[i] = real'(int'($urandom_range(0, 20000)) - 10000);
            n += c[i] * c[i];
        end
        if (n == 0.0) return make_quat(16384, 0, 0, 0);
        n = $sqrt(n);
        q.w = 16'(int'(c[0] / n * 16384.0));
        q.x = 16'(int'(c[1] / n * 16384.0));
        q.y = 16'(int'(c[2] / n * 16384.0));
        q.z = 16'(int'(c[3] / n * 16384.0));
        return q;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch at result %0d: %s got %0d expected %0d",
                 words_out, what, got, want);
        errors++;
    endtask

    // Driver: presents the next pending word once its drawn wait has run out.
    always @(negedge aclk) begin : driver
        quat_t q;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || in_fire) begin
            if (send_wait > 0) begin
                send_wait = send_wait - 1;
                s_valid <= 1'b0;
            end else if (pending_quats.size() != 0) begin
                q = pending_quats.pop_front();
                s_quat_w <= q.w; s_quat_x <= q.x;
                s_quat_y <= q.y; s_quat_z <= q.z;
                s_valid <= 1'b1;
                send_wait = $urandom_range(0, 10);
                if ($urandom_range(0, 2) == 0) send_wait = 0;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Input side: records each accepted word and its predicted angles.
    always @(posedge aclk) begin : input_monitor
        in_fire = aresetn && s_valid && s_ready;
        if (in_fire) begin
            expected_angles.push_back(euler_of(make_quat(s_quat_w, s_quat_x,
                                                         s_quat_y, s_quat_z)));
            words_in++;
        end
    end

    // Receiver: waits a drawn number of cycles per word, and holds off for a
    // long stretch once on request.
    always @(negedge aclk) begin : receiver
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (hold_req && !hold_taken) begin
                hold_taken = 1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left = hold_left - 1;
                m_ready <= 1'b0;
            end else if (out_fire) begin
                recv_wait = $urandom_range(0, 10);
                if ($urandom_range(0, 2) == 0) recv_wait = 0;
                m_ready <= (recv_wait == 0);
            end else if (recv_wait > 0) begin
                recv_wait = recv_wait - 1;
                m_ready <= (recv_wait == 0);
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Monitor: compares each accepted result word with the oldest prediction.
    always @(posedge aclk) begin : monitor
        euler_t e;
        out_fire = aresetn && m_valid && m_ready;
        if (out_fire) begin
            words_out++;
            if (expected_angles.size() == 0) begin
                report_mismatch("result count", words_out, words_in);
            end else begin
                e = expected_angles.pop_front();
                if (m_roll_angle !== e.roll) report_mismatch("roll", m_roll_angle, e.roll);
                if (m_pitch_angle !== e.pitch)
                    report_mismatch("pitch", m_pitch_angle, e.pitch);
                if (m_yaw_angle !== e.yaw) report_mismatch("yaw", m_yaw_angle, e.yaw);
            end
        end
    end

    // Watchdog: counts cycles with no word accepted on either side.
    always @(posedge aclk) begin : watchdog
        if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WD_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin : stimulus
        int r, v;
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed: identity, extremes, zero vectors, pi cases, clamped pitch.
        pending_quats.push_back(make_quat(16384, 0, 0, 0));
        pending_quats.push_back(make_quat(0, 0, 0, 0));
        pending_quats.push_back(make_quat(0, 16384, 0, 0));
        pending_quats.push_back(make_quat(0, 0, 16384, 0));
        pending_quats.push_back(make_quat(0, 0, 0, 16384));
        pending_quats.push_back(make_quat(11585, 0, 11585, 0));
        pending_quats.push_back(make_quat(11585, 0, -11585, 0));
        pending_quats.push_back(make_quat(32767, 32767, 32767, 32767));
        pending_quats.push_back(make_quat(-32768, -32768, -32768, -32768));
        pending_quats.push_back(make_quat(32767, -32768, 32767, -32768));
        pending_quats.push_back(make_quat(-32768, 32767, -32768, 32767));
        pending_quats.push_back(make_quat(32767, 0, 32767, 0));
        pending_quats.push_back(make_quat(32767, 0, -32768, 0));
        pending_quats.push_back(make_quat(0, 32767, 0, 32767));
        pending_quats.push_back(make_quat(0, -32768, 0, 32767));
        pending_quats.push_back(make_quat(16384, 16384, 16384, 16384));
        pending_quats.push_back(make_quat(-1, -1, -1, -1));
        pending_quats.push_back(make_quat(1, 0, 0, 0));
        pending_quats.push_back(make_quat(0, 23170, 23170, 0));
        pending_quats.push_back(make_quat(0, 0, 23170, 23170));
        wait (pending_quats.size() == 0);

        // Long receiver hold-off while the sender keeps offering words.
        hold_req = 1;
        for (int i = 0; i < 150; i++) pending_quats.push_back(unit_quat());
        wait (hold_taken && hold_left == 0);
        wait (pending_quats.size() == 0);

        // Sender pause until every expected result has come.
        wait (expected_angles.size() == 0 && !s_valid);

        // Random: mostly unit quaternions, some raw full-range noise, the rest with w and y at opposite extremes.
        for (int i = 0; i < N_RANDOM - 150; i++) begin
            r = $urandom_range(0, 9);
            if (r < 7) pending_quats.push_back(unit_quat());
            else if (r < 9) pending_quats.push_back(make_quat($urandom(), $urandom(),
                                                    $urandom(), $urandom()));
            else begin
                v = $urandom_range(0, 1) ? 32767 : -32768;
                pending_quats.push_back(make_quat(v, $urandom(), -v - 1, $urandom()));
            end
            while (pending_quats.size() > 64) @(posedge aclk);
        end
        wait (pending_quats.size() == 0);
        @(negedge aclk);
        wait (expected_angles.size() == 0 && !s_valid);
        repeat (LATENCY * 4) @(posedge aclk);

        $display("Converted %0d quaternion words, checked %0d angle words,", words_in,
                 words_out);
        $display("including extremes, unnormalized inputs and a long output stall.");
        if (errors == 0 && expected_angles.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule

// ===== filelist.f =====
rtl/qte_pkg.sv
rtl/qte_front.sv
rtl/qte_sqrt.sv
rtl/qte_cordic.sv
rtl/quaternion_to_euler_angles_unit.sv
rtl/qte_checker.sv
test/quaternion_to_euler_angles_unit_tb.sv
